FILE: rtl/core/clustered_transposition_table_core_defines.svh
// assertion macros for the clustered transposition table core
`ifndef CLUSTERED_TRANSPOSITION_TABLE_CORE_DEFINES_SVH
`define CLUSTERED_TRANSPOSITION_TABLE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CTT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ctt_pkg.sv
// shared types and constants of the clustered transposition table
`timescale 1ns / 1ps

package ctt_pkg;

	localparam int CLUSTER_COUNT = 4096;
	localparam int WAYS         = 3;
	localparam int IDX_W        = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
	localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [26:0] PNDN_INF = 27'd100000000;
	localparam logic [15:0] DIST_INF = 16'hFFFF;

	localparam logic [1:0] OP_LOOKUP     = 2'd0;
	localparam logic [1:0] OP_UPDATE     = 2'd1;
	localparam logic [1:0] OP_NEW_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] key;
		logic        root_side;
		logic [26:0] new_pn;
		logic [26:0] new_dn;
		logic [15:0] new_min_distance;
		logic [31:0] new_visits;
	} req_t;

	typedef struct packed {
		logic [26:0] pn;
		logic [26:0] dn;
		logic [15:0] min_distance;
		logic [31:0] visits;
		logic        hit;
		logic [1:0]  way;
	} rsp_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [15:0] gen;
		logic [26:0] pn;
		logic [26:0] dn;
		logic [15:0] distance;
		logic [31:0] visits;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

endpackage

FILE: rtl/core/clustered_transposition_table_core.sv
// clustered transposition table core: row memory, lookup and write-back
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | ctt_pkg::req_t
//  rsp     | out | rsp_valid/rsp_ready  | ctt_pkg::rsp_t
//
// per request the cluster row is read when the request is taken, then the way is chosen and the row written back
// the registered read of the row memory (one cluster per row) comes ahead of the write-back
// after reset a clearing pass writes zero to every row (CLUSTER_COUNT rows, 4096), no request taken
// the response register holds while rsp_ready is low; a new request is taken meanwhile,
// but its write-back waits until the response register frees
`timescale 1ns / 1ps

module clustered_transposition_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ctt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ctt_pkg::rsp_t rsp
);
	import ctt_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_LOOK  = 3'b100
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_cnt_q;
	logic [15:0]        cur_gen_q;
	req_t               req_q;
	logic [IDX_W-1:0]   idx_q;
	row_t               row_q;
	row_t               row_mem [CLUSTER_COUNT];
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               out_free;
	logic               fire;
	logic [IDX_W-1:0]   req_idx;
	logic [31:0]        req_tag;
	logic               hit;
	logic               stale_found;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   stale_way;
	logic [WAY_W-1:0]   best_way;
	logic [WAY_W-1:0]   way_sel;
	entry_t             entry_new;
	row_t               row_new;
	rsp_t               rsp_next;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	row_t               mem_wdata;

	function automatic logic [26:0] sat_pndn(input logic [26:0] v);
		return (v > PNDN_INF) ? PNDN_INF : v;
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign fire      = (state_q == S_LOOK) && out_free;
	assign req_idx   = req.key[IDX_W-1:0] & IDX_W'(CLUSTER_COUNT - 1);
	assign req_tag   = {req_q.key[63:33], req_q.root_side};

	always_comb begin
		hit         = 1'b0;
		stale_found = 1'b0;
		hit_way     = '0;
		stale_way   = '0;
		best_way    = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_q[w].tag == req_tag && row_q[w].gen == cur_gen_q) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (row_q[w].gen != cur_gen_q) begin
				stale_found = 1'b1;
				stale_way   = WAY_W'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (row_q[w].visits < row_q[best_way].visits) begin
				best_way = WAY_W'(w);
			end
		end
		way_sel = hit ? hit_way : (stale_found ? stale_way : best_way);

		entry_new = row_q[way_sel];
		if (!hit) begin
			entry_new.tag      = req_tag;
			entry_new.gen      = cur_gen_q;
			entry_new.pn       = 27'd1;
			entry_new.dn       = 27'd1;
			entry_new.distance = DIST_INF;
			entry_new.visits   = '0;
		end
		if (req_q.op == OP_UPDATE) begin
			entry_new.pn       = sat_pndn(req_q.new_pn);
			entry_new.dn       = sat_pndn(req_q.new_dn);
			entry_new.distance = req_q.new_min_distance;
			entry_new.visits   = req_q.new_visits;
		end

		row_new          = row_q;
		row_new[way_sel] = entry_new;
	end

	always_comb begin
		rsp_next = '0;
		case (req_q.op) inside
			OP_LOOKUP, OP_UPDATE: begin
				rsp_next.pn           = entry_new.pn;
				rsp_next.dn           = entry_new.dn;
				rsp_next.min_distance = entry_new.distance;
				rsp_next.visits       = entry_new.visits;
				rsp_next.hit          = hit;
				rsp_next.way          = 2'(way_sel);
			end
			default: begin
				rsp_next = '0;
			end
		endcase
	end

	// one write port: clearing pass or write-back
	assign mem_we    = (state_q == S_CLEAR) ||
	                   (fire && (req_q.op == OP_LOOKUP || req_q.op == OP_UPDATE));
	assign mem_addr  = (state_q == S_CLEAR) ? clr_cnt_q : idx_q;
	assign mem_wdata = (state_q == S_CLEAR) ? row_t'('0) : row_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_addr] <= mem_wdata;
		end
		if (accept) begin
			row_q <= row_mem[req_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			idx_q <= req_idx;
		end
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			cur_gen_q   <= 16'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IDX_W'(CLUSTER_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire && req_q.op == OP_NEW_SEARCH) begin
				cur_gen_q <= cur_gen_q + 16'd1;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/ctt_checker.sv
// port checker for the clustered transposition table core and its bind
`timescale 1ns / 1ps
`include "clustered_transposition_table_core_defines.svh"

module ctt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ctt_pkg::rsp_t rsp
);
	import ctt_pkg::*;

	`CTT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

	`CTT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "second request taken while one is in flight")

	`CTT_ASSERT_SAME(a_rsp_after_lookup, clk, arst_n, $rose(rsp_valid), !$past(req_ready), "response appeared without a lookup cycle")

endmodule

bind clustered_transposition_table_core ctt_checker u_ctt_checker (.*);

FILE: verif/tb_clustered_transposition_table_core.sv
`timescale 1ns / 1ps
// testbench of the clustered transposition table core: table model, scoreboard and random requests

module tb_clustered_transposition_table_core;
	import ctt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ENTRIES = CLUSTER_COUNT * WAYS;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_ITEMS = 450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	entry_t table_model [ENTRIES];
	logic [15:0] search_gen;
	rsp_t node_result_q [$];
	rsp_t want;
	int send_idle_pct = 13;
	int recv_idle_pct = 54;
	int mismatches = 0;
	int stall_cycles;

	clustered_transposition_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rsp_t probe_table(input req_t r);
		rsp_t res;
		logic [31:0] tag;
		int base;
		int slot;
		int w;
		logic found;
		res = '0;
		if (r.op == OP_NEW_SEARCH) begin
			search_gen = search_gen + 16'd1;
			return res;
		end
		if (r.op == OP_UNUSED)
			return res;
		base = int'(r.key & 64'(CLUSTER_COUNT - 1)) * WAYS;
		tag = {r.key[63:33], r.root_side};
		found = 1'b0;
		slot = -1;
		for (w = 0; w < WAYS; w++) begin
			if (!found && table_model[base + w].tag == tag &&
					table_model[base + w].gen == search_gen) begin
				found = 1'b1;
				slot = w;
			end
		end
		if (!found) begin
			for (w = 0; w < WAYS; w++) begin
				if (slot < 0 && table_model[base + w].gen != search_gen)
					slot = w;
			end
			if (slot < 0) begin
				slot = 0;
				for (w = 1; w < WAYS; w++) begin
					if (table_model[base + w].visits < table_model[base + slot].visits)
						slot = w;
				end
			end
			table_model[base + slot] = '{tag: tag, gen: search_gen, pn: 27'd1, dn: 27'd1,
				distance: DIST_INF, visits: 32'd0};
		end
		if (r.op == OP_UPDATE) begin
			table_model[base + slot].pn = (r.new_pn > PNDN_INF) ? PNDN_INF : r.new_pn;
			table_model[base + slot].dn = (r.new_dn > PNDN_INF) ? PNDN_INF : r.new_dn;
			table_model[base + slot].distance = r.new_min_distance;
			table_model[base + slot].visits = r.new_visits;
		end
		res.pn = table_model[base + slot].pn;
		res.dn = table_model[base + slot].dn;
		res.min_distance = table_model[base + slot].distance;
		res.visits = table_model[base + slot].visits;
		res.hit = found;
		res.way = 2'(slot);
		return res;
	endfunction

	function automatic req_t make_req(input logic [1:0] op, input logic [63:0] key,
			input logic color, input logic [26:0] pn, input logic [26:0] dn,
			input logic [15:0] min_dist, input logic [31:0] visits);
		req_t r;
		r.op = op;
		r.key = key;
		r.root_side = color;
		r.new_pn = pn;
		r.new_dn = dn;
		r.new_min_distance = min_dist;
		r.new_visits = visits;
		return r;
	endfunction

	function automatic logic [26:0] random_pndn();
		case ($urandom_range(3))
			0: return 27'($urandom());
			1: return 27'($urandom_range(10));
			2: return PNDN_INF;
			default: return 27'($urandom_range(27'h7FFFFFF, 100000000));
		endcase
	endfunction

	task automatic send_request(input req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		node_result_q = {node_result_q, probe_table(item)};
	endtask

	task automatic test_directed();
		logic [31:0] lo;
		lo = 32'h5;
		send_request(make_req(OP_LOOKUP, 64'd0, 1'b0, '0, '0, '0, '0));
		send_request(make_req(OP_LOOKUP, 64'd0, 1'b0, '0, '0, '0, '0));
		send_request(make_req(OP_LOOKUP, 64'd0, 1'b1, '1, '1, '1, '1));
		// oversized pn and dn saturate
		send_request(make_req(OP_UPDATE, '1, 1'b1, 27'h7FFFFFF, PNDN_INF + 27'd1,
			16'hFFFF, 32'hFFFFFFFF));
		send_request(make_req(OP_UPDATE, '1, 1'b1, '0, '0, '0, '0));
		send_request(make_req(OP_UPDATE, '1, 1'b1, PNDN_INF, PNDN_INF, DIST_INF, '1));
		// fill one cluster with every way at maximum visits, tie goes to way 0
		send_request(make_req(OP_UPDATE, {32'h1000_0000, lo}, 1'b0, 27'd5, 27'd6,
			16'd7, 32'hFFFFFFFF));
		send_request(make_req(OP_UPDATE, {32'h2000_0000, lo}, 1'b0, 27'd8, 27'd9,
			16'd10, 32'hFFFFFFFF));
		send_request(make_req(OP_UPDATE, {32'h3000_0000, lo}, 1'b0, 27'd11, 27'd12,
			16'd13, 32'hFFFFFFFF));
		send_request(make_req(OP_LOOKUP, {32'h4000_0000, lo}, 1'b0, '0, '0, '0, '0));
		// fewest visits wins the eviction
		send_request(make_req(OP_UPDATE, {32'h4000_0000, lo}, 1'b0, 27'd1, 27'd2,
			16'd3, 32'd9));
		send_request(make_req(OP_UPDATE, {32'h2000_0000, lo}, 1'b0, 27'd1, 27'd2,
			16'd3, 32'd7));
		send_request(make_req(OP_UPDATE, {32'h3000_0000, lo}, 1'b0, 27'd1, 27'd2,
			16'd3, 32'd3));
		send_request(make_req(OP_LOOKUP, {32'h5000_0000, lo}, 1'b1, '0, '0, '0, '0));
		// upper index bits and key bit 32 do not matter
		send_request(make_req(OP_LOOKUP, {32'h2000_0000, 32'hABCDE005}, 1'b0, '0, '0, '0, '0));
		send_request(make_req(OP_LOOKUP, {32'h2000_0001, lo}, 1'b0, '0, '0, '0, '0));
		send_request(make_req(OP_UNUSED, '1, 1'b1, '1, '1, '1, '1));
		send_request(make_req(OP_NEW_SEARCH, {$urandom(), $urandom()}, 1'b1,
			27'($urandom()), 27'($urandom()), 16'($urandom()), $urandom()));
		// entries of the old generation are reclaimed
		send_request(make_req(OP_LOOKUP, 64'd0, 1'b0, '0, '0, '0, '0));
		send_request(make_req(OP_LOOKUP, {32'h5000_0000, lo}, 1'b1, '0, '0, '0, '0));
		send_request(make_req(OP_UPDATE, 64'd0, 1'b0, 27'd42, 27'd43, 16'd44, 32'd45));
		send_request(make_req(OP_LOOKUP, {32'h2000_0000, lo}, 1'b0, '0, '0, '0, '0));
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int count);
		logic [31:0] hot_tag [5];
		int hot_cluster [6];
		req_t r;
		int pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		foreach (hot_tag[i])
			hot_tag[i] = $urandom();
		foreach (hot_cluster[i])
			hot_cluster[i] = $urandom_range(CLUSTER_COUNT - 1);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 40)
				r.op = OP_UPDATE;
			else if (pick < 94)
				r.op = OP_LOOKUP;
			else if (pick < 98)
				r.op = OP_NEW_SEARCH;
			else
				r.op = OP_UNUSED;
			if ($urandom_range(9) < 8)
				r.key = {hot_tag[$urandom_range(4)], ($urandom() & ~32'(CLUSTER_COUNT - 1)) |
					32'(hot_cluster[$urandom_range(5)])};
			else
				r.key = {$urandom(), $urandom()};
			r.root_side = 1'($urandom_range(1));
			r.new_pn = random_pndn();
			r.new_dn = random_pndn();
			r.new_min_distance = ($urandom_range(3) == 0) ? DIST_INF : 16'($urandom());
			case ($urandom_range(3))
				0: r.new_visits = 32'($urandom_range(3));
				1: r.new_visits = 32'hFFFFFFFF;
				default: r.new_visits = $urandom();
			endcase
			send_request(r);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (node_result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: pn %0d dn %0d dist %0d visits %0d hit %0d way %0d",
						rsp.pn, rsp.dn, rsp.min_distance, rsp.visits, rsp.hit, rsp.way);
			end else begin
				want = node_result_q.pop_front();
				if (rsp.pn !== want.pn || rsp.dn !== want.dn ||
						rsp.min_distance !== want.min_distance || rsp.visits !== want.visits ||
						rsp.hit !== want.hit || rsp.way !== want.way) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch expected: pn %0d dn %0d dist %0d visits %0d hit %0d way %0d",
							want.pn, want.dn, want.min_distance, want.visits, want.hit, want.way);
						$display("         actual:   pn %0d dn %0d dist %0d visits %0d hit %0d way %0d",
							rsp.pn, rsp.dn, rsp.min_distance, rsp.visits, rsp.hit, rsp.way);
					end
				end
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			table_model[i] = '0;
		search_gen = 16'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(13, 54, PHASE_ITEMS);
		test_random(54, 13, PHASE_ITEMS);
		test_random(0, 0, PHASE_ITEMS);
		req_valid <= 1'b0;
		while (node_result_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
